@@ hw/rtl/cit_pkg.sv @@
// ----------------------------------------------------------------------------
// cit_pkg: shared types and constants for the idle timeout table
// Sizes, input function codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package cit_pkg;

	localparam int MAX_CONN = 64;
	localparam int IDX_W    = $clog2(MAX_CONN);
	localparam int CNT_W    = $clog2(MAX_CONN + 1);
	localparam int CONN_W   = 6;
	localparam int TIME_W   = 32;
	localparam int TMO_W    = 16;

	localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd15;

	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_ARM  = 1'b1;

	typedef struct packed {
		logic arm;
		logic tick;
		logic scan_start;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic count_zero;
		logic count_one;
		logic out_busy;
	} status_t;

endpackage

@@ hw/rtl/cit_dp.sv @@
// ----------------------------------------------------------------------------
// cit_dp: idle timeout table datapath
// Expiry memory, active bits, time counter, scan pipeline that picks the
// oldest due entry, and the output word register.
// ----------------------------------------------------------------------------
module cit_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cit_pkg::cmd_t                 cmd,
	output cit_pkg::status_t              st,
	input  logic [cit_pkg::CONN_W-1:0]    conn_id,
	input  logic                          cfg_we,
	input  logic [cit_pkg::TMO_W-1:0]     cfg_wdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cit_pkg::CONN_W-1:0]    expired_conn,
	output logic                          last
);

	logic [cit_pkg::TIME_W-1:0] exp_mem [cit_pkg::MAX_CONN];

	logic [cit_pkg::MAX_CONN-1:0] active_q;
	logic [cit_pkg::TIME_W-1:0]   now_q;
	logic [cit_pkg::TMO_W-1:0]    timeout_q;

	logic                        scan_run_q;
	logic [cit_pkg::IDX_W-1:0]   scan_idx_q;

	logic                        v_s1;
	logic [cit_pkg::IDX_W-1:0]   idx_s1;
	logic                        act_s1;
	logic [cit_pkg::TIME_W-1:0]  rd_s1;

	logic                        v_s2;
	logic                        end_s2;
	logic [cit_pkg::IDX_W-1:0]   idx_s2;
	logic                        hit_s2;
	logic [cit_pkg::TIME_W-1:0]  age_s2;

	logic [cit_pkg::CNT_W-1:0]   count_q;
	logic [cit_pkg::IDX_W-1:0]   best_id_q;
	logic [cit_pkg::TIME_W-1:0]  best_age_q;
	logic                        done_q;

	logic                        conn_ok;
	logic [cit_pkg::TIME_W-1:0]  age_c;
	logic                        due_c;

	assign conn_ok = ((cit_pkg::CONN_W+1)'(conn_id) < (cit_pkg::CONN_W+1)'(cit_pkg::MAX_CONN));

	// age = now - expiry; due when expiry - now is zero or negative,
	// i.e. age in [0, 2^31]
	assign age_c = now_q - rd_s1;
	assign due_c = !age_c[cit_pkg::TIME_W-1] ||
		(age_c == {1'b1, {(cit_pkg::TIME_W-1){1'b0}}});

	always_ff @(posedge clk) begin
		if (cmd.arm && conn_ok) begin
			exp_mem[conn_id[cit_pkg::IDX_W-1:0]] <= now_q + cit_pkg::TIME_W'(timeout_q);
		end
		rd_s1 <= exp_mem[scan_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= '0;
			now_q      <= '0;
			timeout_q  <= cit_pkg::TIMEOUT_RESET;
			scan_run_q <= 1'b0;
			scan_idx_q <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			count_q    <= '0;
			done_q     <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (cmd.tick) begin
				now_q <= now_q + 1'b1;
			end
			if (cmd.arm && conn_ok) begin
				active_q[conn_id[cit_pkg::IDX_W-1:0]] <= 1'b1;
			end
			if (cmd.emit) begin
				active_q[best_id_q] <= 1'b0;
			end

			// read stage
			if (cmd.scan_start) begin
				scan_run_q <= 1'b1;
				scan_idx_q <= '0;
			end else if (scan_run_q) begin
				if (scan_idx_q == cit_pkg::IDX_W'(cit_pkg::MAX_CONN - 1)) begin
					scan_run_q <= 1'b0;
				end else begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
			end
			v_s1 <= scan_run_q && !cmd.scan_start;

			v_s2 <= v_s1;

			// accumulate: strict greater keeps the lower connection on ties
			done_q <= v_s2 && end_s2;
			if (cmd.scan_start) begin
				count_q <= '0;
			end else if (v_s2 && hit_s2) begin
				count_q <= count_q + 1'b1;
			end

			if (cmd.emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx_q;
		act_s1 <= active_q[scan_idx_q];

		idx_s2 <= idx_s1;
		end_s2 <= (idx_s1 == cit_pkg::IDX_W'(cit_pkg::MAX_CONN - 1));
		hit_s2 <= act_s1 && due_c;
		age_s2 <= age_c;

		if (v_s2 && hit_s2 && ((count_q == '0) || (age_s2 > best_age_q))) begin
			best_id_q  <= idx_s2;
			best_age_q <= age_s2;
		end

		if (cmd.emit) begin
			expired_conn <= cit_pkg::CONN_W'(best_id_q);
			last         <= (count_q == cit_pkg::CNT_W'(1));
		end
	end

	assign st.scan_done  = done_q;
	assign st.count_zero = (count_q == '0);
	assign st.count_one  = (count_q == cit_pkg::CNT_W'(1));
	assign st.out_busy   = out_valid && !out_ready;

endmodule

@@ hw/rtl/cit_ctrl.sv @@
// ----------------------------------------------------------------------------
// cit_ctrl: idle timeout table controller
// Takes input words, runs one scan per expired connection (one scan when
// none is due) and hands each winner to the output register.
// ----------------------------------------------------------------------------
module cit_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             func,
	output logic             in_ready,
	input  cit_pkg::status_t st,
	output cit_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   accept;
	logic   emit_ok;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign emit_ok  = (state_q == S_EMIT) && !st.out_busy;

	always_comb begin
		cmd.arm        = accept && (func == cit_pkg::FUNC_ARM);
		cmd.tick       = accept && (func == cit_pkg::FUNC_TICK);
		cmd.emit       = emit_ok;
		cmd.scan_start = cmd.tick || (emit_ok && !st.count_one);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && (func == cit_pkg::FUNC_TICK)) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (st.scan_done) begin
						state_q <= st.count_zero ? S_IDLE : S_EMIT;
					end
				end
				S_EMIT: begin
					if (!st.out_busy) begin
						state_q <= st.count_one ? S_IDLE : S_SCAN;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/connection_idle_timeout_table.sv @@
// ----------------------------------------------------------------------------
// connection_idle_timeout_table: per-connection idle timeout table
// Arms connections with an expiry time and reports expirations on ticks.
// ----------------------------------------------------------------------------
// An arm word (func=1) sets the connection active with expiry at now plus
// the configured timeout and leaves the input ready. A tick word (func=0)
// advances time by one and then sends out every due connection, oldest
// expiry first, lowest number on ties, with last set on the final word. The
// expiry store has one read port, and each expired connection costs one
// full pass over it, as does a tick with none due; the output side can stall
// the passes. No new word is taken while a tick is in work.
module connection_idle_timeout_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       func,
	input  logic [cit_pkg::CONN_W-1:0] conn_id,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [cit_pkg::CONN_W-1:0] expired_conn,
	output logic                       last,
	input  logic                       cfg_we,
	input  logic [cit_pkg::TMO_W-1:0]  cfg_wdata
);

	cit_pkg::cmd_t    cmd;
	cit_pkg::status_t st;

	cit_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	cit_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.conn_id      (conn_id),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.expired_conn (expired_conn),
		.last         (last)
	);

endmodule

@@ hw/rtl/cit_checker.sv @@
// ----------------------------------------------------------------------------
// cit_checker: port-level checks for the idle timeout table
// Watches the handshakes and the tick/result sequencing.
// ----------------------------------------------------------------------------
module cit_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       func,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [cit_pkg::CONN_W-1:0] expired_conn,
	input logic                       last
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(expired_conn) && $stable(last))
		else $error("result word changed while stalled");

	// a tick blocks the input while its scan runs
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func == cit_pkg::FUNC_TICK) |=> !in_ready)
		else $error("input taken during tick scan");

	// an arm leaves the controller idle, so the input stays ready
	a_arm_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func == cit_pkg::FUNC_ARM) |=> in_ready)
		else $error("arm did not return to idle");

	// while more results of a tick are due, no new word is taken
	a_more_due: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input ready before final result word");

endmodule

bind connection_idle_timeout_table cit_checker u_cit_checker (.*);

@@ verif/idle_timeout_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_timeout_checker: expiry predictor and result checker
// Watches the input, output and config ports of the idle timeout table, keeps
// its own copy of the connection table and compares every expiry word.
// ----------------------------------------------------------------------------
module idle_timeout_checker
	import cit_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              func,
	input  logic [CONN_W-1:0] conn_id,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [CONN_W-1:0] expired_conn,
	input  logic              last,
	input  logic              cfg_we,
	input  logic [TMO_W-1:0]  cfg_wdata,
	output int                errors,
	output int                pending
);

	typedef struct packed {
		logic [CONN_W-1:0] conn;
		logic              last;
	} expiry_word_t;

	logic [TIME_W-1:0] expiry_at [MAX_CONN];
	logic              armed     [MAX_CONN];
	logic [TIME_W-1:0] clock_now;
	logic [TMO_W-1:0]  idle_limit;
	expiry_word_t      due_q [$];

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		errors++;
	endtask

	// due when expiry - now, read as signed, is zero or negative
	function automatic logic overdue(input logic [TIME_W-1:0] expiry,
		input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] diff;
		diff = expiry - t;
		return (diff == '0) || diff[TIME_W-1];
	endfunction

	task automatic advance_clock();
		int                hit_ids [$];
		logic [TIME_W-1:0] hit_ages [$];
		logic [TIME_W-1:0] age;
		int                pos;
		int                cnt;
		int                i;
		expiry_word_t      w;
		clock_now = clock_now + 1'b1;
		// scan in ascending order; insertion keeps ties by connection number
		for (i = 0; i < MAX_CONN; i++) begin
			if (armed[i] && overdue(expiry_at[i], clock_now)) begin
				age = clock_now - expiry_at[i];
				pos = hit_ids.size();
				while (pos > 0 && hit_ages[pos-1] < age)
					pos--;
				hit_ids.insert(pos, i);
				hit_ages.insert(pos, age);
			end
		end
		cnt = (hit_ids.size() > MAX_CONN) ? MAX_CONN : hit_ids.size();
		for (i = 0; i < cnt; i++) begin
			armed[hit_ids[i]] = 1'b0;
			w.conn = hit_ids[i][CONN_W-1:0];
			w.last = (i == cnt - 1);
			due_q.insert(due_q.size(), w);
		end
	endtask

	task automatic check_word();
		expiry_word_t want;
		if (due_q.size() == 0) begin
			report_mismatch($sformatf("unexpected expiry word conn=%0d last=%0d",
				expired_conn, last));
		end else begin
			want = due_q.pop_front();
			if (expired_conn !== want.conn)
				report_mismatch($sformatf("expired_conn %0d, expected %0d",
					expired_conn, want.conn));
			if (last !== want.last)
				report_mismatch($sformatf("last %0d on conn %0d, expected %0d",
					last, want.conn, want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CONN; i++) begin
				armed[i] = 1'b0;
				expiry_at[i] = '0;
			end
			clock_now = '0;
			idle_limit = TIMEOUT_RESET;
			due_q.delete();
			errors = 0;
			pending <= 0;
		end else begin
			// results come out before any word accepted on the same edge
			if (out_valid && out_ready)
				check_word();
			// an arm on the same edge as a config write still sees the old timeout
			if (in_valid && in_ready) begin
				if (func == FUNC_ARM) begin
					expiry_at[conn_id] = clock_now + idle_limit;
					armed[conn_id] = 1'b1;
				end else begin
					advance_clock();
				end
			end
			if (cfg_we)
				idle_limit = cfg_wdata;
			pending <= due_q.size();
		end
	end

endmodule

@@ verif/connection_idle_timeout_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connection_idle_timeout_table_tb: testbench for the idle timeout table
// Directed arm/refresh/tick sequences, then random mixes over several
// timeouts, a full-table expiry under output back-pressure, and random idling.
// ----------------------------------------------------------------------------
module connection_idle_timeout_table_tb;
	import cit_pkg::*;

	localparam int SETTLE      = 2 * (MAX_CONN + 4);
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4 * (MAX_CONN * (MAX_CONN + 4) + HOLD_CYCLES + 200);

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              func      = FUNC_TICK;
	logic [CONN_W-1:0] conn_id   = '0;
	logic              out_ready = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [TMO_W-1:0]  cfg_wdata = '0;
	logic              in_ready;
	logic              out_valid;
	logic [CONN_W-1:0] expired_conn;
	logic              last;

	int   errors;
	int   pending;
	int   burst_left   = 0;
	int   stall_cycles = 0;
	logic hold_req     = 1'b0;
	logic hold_done    = 1'b0;
	int   hold_left    = 0;
	int   rx_mode      = 0;
	int   rx_left      = 0;

	always #1 clk = ~clk;

	connection_idle_timeout_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.conn_id(conn_id),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.expired_conn(expired_conn),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	idle_timeout_checker expiry_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.conn_id(conn_id),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.expired_conn(expired_conn),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.errors(errors),
		.pending(pending)
	);

	// receiver: random stall modes, plus one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= $urandom_range(0, 3);
				rx_left <= $urandom_range(16, 96);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (rx_left % 3 != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("connection_idle_timeout_table_tb failed");
				$finish;
			end
		end
	end

	// returns on the edge at which the word is accepted
	task automatic send_word(input logic f, input logic [CONN_W-1:0] id);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		func <= f;
		conn_id <= id;
		do @(posedge clk); while (!in_ready);
		burst_left--;
	endtask

	task automatic arm(input int id);
		send_word(FUNC_ARM, id[CONN_W-1:0]);
	endtask

	// conn_id is don't-care on a tick, so it carries noise
	task automatic tick();
		send_word(FUNC_TICK, CONN_W'($urandom_range(0, MAX_CONN - 1)));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		// a tick with no expiry still runs a full scan
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_timeout(input logic [TMO_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_mix(input int n, input int arm_pct);
		int k;
		int base;
		base = $urandom_range(0, MAX_CONN - 8);
		for (k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < arm_pct) begin
				// a narrow window of ids makes refreshes common
				if ($urandom_range(0, 3) == 0)
					arm($urandom_range(0, MAX_CONN - 1));
				else
					arm(base + $urandom_range(0, 7));
			end else begin
				tick();
			end
		end
	endtask

	initial begin
		int order [MAX_CONN];
		int k;
		int j;
		int t;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset timeout: these expire much later, after the timeout changes
		arm(0);
		arm(MAX_CONN - 1);
		arm(42);
		tick();
		tick();

		set_timeout(16'd3);
		arm(21);
		arm(42);          // refresh of an active entry
		tick();
		tick();
		arm(21);          // refresh pushes expiry out again
		tick();           // 42 expires alone
		tick();           // nothing due
		arm(42);          // refresh of an expired entry acts as an add
		tick();           // 21 expires
		tick();
		tick();           // 42 expires

		set_timeout(16'd1);
		arm(MAX_CONN - 1);
		arm(0);
		arm(1);
		tick();           // three due on one tick, ascending order

		set_timeout(16'hFFFF);
		arm(21);
		tick();

		set_timeout(16'd4);
		run_mix(40, 50);
		set_timeout(16'hFFFF);
		run_mix(20, 70);

		// whole table due on one tick, with the output held off
		set_timeout(16'd1);
		for (k = 0; k < MAX_CONN; k++)
			order[k] = k;
		for (k = MAX_CONN - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			t = order[k];
			order[k] = order[j];
			order[j] = t;
		end
		for (k = 0; k < MAX_CONN; k++)
			arm(order[k]);
		hold_req <= 1'b1;
		tick();
		repeat (3) begin
			arm($urandom_range(0, MAX_CONN - 1));
			tick();
		end

		set_timeout(TMO_W'($urandom_range(2, 6)));
		run_mix(50, 45);
		set_timeout(TMO_W'($urandom_range(1, 16'hFFFF)));
		run_mix(20, 60);
		set_timeout(16'd2);
		run_mix(40, 50);

		drain();
		if (errors == 0)
			$display("connection_idle_timeout_table_tb passed");
		else
			$display("connection_idle_timeout_table_tb failed");
		$finish;
	end

endmodule
